// ----- src/assert_macros.svh -----
// Assertion macros shared by the cipher unit modules.
// Depends on nothing; included by files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

// ----- src/aes_pkg.sv -----
// Package for the AES cipher unit: payload types, control types, S-boxes, GF helpers.
// Depends on nothing.
`default_nettype none
package aes_pkg;
   localparam int KeyWords = 60;
   localparam logic [2:0] CsrKeyMode = 3'd0;
   localparam logic [2:0] CsrKey0 = 3'd1;
   localparam logic [2:0] CsrKey1 = 3'd2;
   localparam logic [2:0] CsrKey2 = 3'd3;
   localparam logic [2:0] CsrKey3 = 3'd4;

   typedef struct packed {
      logic        action;
      logic [63:0] block_upper;
      logic [63:0] block_lower;
   } req_type;

   typedef struct packed {
      logic [63:0] result_upper;
      logic [63:0] result_lower;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE, ST_KEY_LOAD, ST_KEY_EXP, ST_INIT, ST_ROUND, ST_OUT
   } state_type;

   typedef struct packed {
      logic       key_load;
      logic       key_exp;
      logic       load_block;
      logic       init_add;
      logic       do_round;
      logic       last_round;
      logic       rsp_load;
      logic [5:0] key_idx;
      logic [3:0] round;
   } cmd_type;

   typedef struct packed {
      logic [3:0] nk;
      logic [3:0] nr;
      logic       decrypt;
   } sts_type;

   function automatic logic [7:0] sbox(input logic [7:0] x);
      logic [7:0] t [256];
      t = '{
 8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
 8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
 8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
 8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
 8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
 8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
 8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
 8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
 8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
 8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
 8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
 8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
 8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
 8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
 8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
 8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
      return t[x];
   endfunction

   function automatic logic [7:0] inv_sbox(input logic [7:0] x);
      logic [7:0] t [256];
      t = '{
 8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
 8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
 8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
 8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
 8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
 8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
 8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
 8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
 8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
 8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
 8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
 8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
 8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
 8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
 8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
 8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d};
      return t[x];
   endfunction

   function automatic logic [7:0] xtime(input logic [7:0] v);
      return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
   endfunction

   function automatic logic [31:0] sub_word(input logic [31:0] w);
      return {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
   endfunction
endpackage
`default_nettype wire

// ----- src/aes_datapath.sv -----
// Datapath of the AES cipher unit: key registers, round-key memory, key expansion, state rounds.
// Depends on aes_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module aes_datapath
   import aes_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_write,
   input  wire logic [2:0]  csr_index,
   input  wire logic [63:0] csr_data,
   input  wire req_type     req_data,
   input  wire cmd_type     cmd,
   output sts_type          sts,
   output rsp_type          rsp_data
);
   logic [1:0]   key_mode_ff;
   logic [63:0]  key_part_ff [4];
   logic [31:0]  rk_bank [4][KeyWords/4];
   logic [31:0]  win_ff [8];
   logic [31:0]  win_in [8];
   logic [7:0]   rcon_ff, rcon_in;
   logic [2:0]   pos_ff, pos_in;
   logic [127:0] st_ff, st_in;
   logic         dec_ff;
   rsp_type      rsp_ff;
   logic [1:0]   mode;
   logic [3:0]   nk;
   logic [31:0]  t, neww;
   logic [31:0]  rk_q [4];
   logic [127:0] rk;
   logic [127:0] fwd, inv;

   assign mode = (key_mode_ff == 2'd3) ? 2'd2 : key_mode_ff;
   assign nk = 4'd4 + {1'b0, mode, 1'b0};
   assign sts.nk = nk;
   assign sts.nr = nk + 4'd6;
   assign sts.decrypt = dec_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_mode_ff <= '0;
         for (int i = 0; i < 4; i++) key_part_ff[i] <= '0;
      end else if (csr_write) begin
         unique case (csr_index)
            CsrKeyMode: key_mode_ff <= csr_data[1:0];
            CsrKey0: key_part_ff[0] <= csr_data;
            CsrKey1: key_part_ff[1] <= csr_data;
            CsrKey2: key_part_ff[2] <= csr_data;
            CsrKey3: key_part_ff[3] <= csr_data;
            default: ;
         endcase
      end
   end

   // A sliding window of the last Nk words; word Nk-1 is the newest.
   always_comb begin
      t = win_ff[nk[2:0] - 3'd1];
      if (pos_ff == 3'd0)
         t = sub_word({t[23:0], t[31:24]}) ^ {rcon_ff, 24'h0};
      else if (nk == 4'd8 && pos_ff == 3'd4)
         t = sub_word(t);
      neww = win_ff[0] ^ t;
      for (int i = 0; i < 8; i++) win_in[i] = win_ff[i];
      rcon_in = rcon_ff;
      pos_in = pos_ff;
      if (cmd.key_load) begin
         for (int i = 0; i < 4; i++) begin
            win_in[2*i] = key_part_ff[i][63:32];
            win_in[2*i+1] = key_part_ff[i][31:0];
         end
         rcon_in = 8'h01;
         pos_in = 3'd0;
      end else if (cmd.key_exp && cmd.key_idx >= {2'b0, nk}) begin
         for (int i = 0; i < 7; i++) win_in[i] = win_ff[i+1];
         win_in[nk[2:0] - 3'd1] = neww;
         if (pos_ff == 3'd0) rcon_in = xtime(rcon_ff);
         pos_in = (pos_ff == nk[2:0] - 3'd1) ? 3'd0 : pos_ff + 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 8; i++) win_ff[i] <= win_in[i];
      rcon_ff <= rcon_in;
      pos_ff <= pos_in;
   end

   // Words below Nk come straight from the key; later ones from the window.
   // Word 4*round+c of the schedule sits in bank c, so a round reads each bank once.
   always_ff @(posedge clock) begin
      if (cmd.key_exp)
         rk_bank[cmd.key_idx[1:0]][cmd.key_idx[5:2]] <=
            (cmd.key_idx < {2'b0, nk}) ? win_ff[cmd.key_idx[2:0]] : neww;
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 4; i++) rk_q[i] <= rk_bank[i][cmd.round];
   end
   assign rk = {rk_q[0], rk_q[1], rk_q[2], rk_q[3]};

   always_comb begin
      logic [7:0] b [16];
      logic [7:0] f [16];
      logic [7:0] g [16];
      logic [7:0] m [16];
      logic [7:0] a0, a1, a2, a3, d0, d1, d2, d3, q0, q1, q2, q3;
      for (int i = 0; i < 16; i++) b[i] = st_ff[127-8*i -: 8];
      // Forward: SubBytes, ShiftRows, MixColumns, AddRoundKey.
      for (int c = 0; c < 4; c++)
         for (int r = 0; r < 4; r++)
            f[c*4+r] = sbox(b[((c + r) % 4)*4 + r]);
      for (int c = 0; c < 4; c++) begin
         a0 = f[c*4]; a1 = f[c*4+1]; a2 = f[c*4+2]; a3 = f[c*4+3];
         d0 = xtime(a0); d1 = xtime(a1); d2 = xtime(a2); d3 = xtime(a3);
         m[c*4]   = cmd.last_round ? a0 : d0 ^ d1 ^ a1 ^ a2 ^ a3;
         m[c*4+1] = cmd.last_round ? a1 : a0 ^ d1 ^ d2 ^ a2 ^ a3;
         m[c*4+2] = cmd.last_round ? a2 : a0 ^ a1 ^ d2 ^ d3 ^ a3;
         m[c*4+3] = cmd.last_round ? a3 : d0 ^ a0 ^ a1 ^ a2 ^ d3;
      end
      for (int i = 0; i < 16; i++) fwd[127-8*i -: 8] = m[i] ^ rk[127-8*i -: 8];
      // Inverse: InvShiftRows, InvSubBytes, AddRoundKey, InvMixColumns.
      for (int c = 0; c < 4; c++)
         for (int r = 0; r < 4; r++)
            g[c*4+r] = inv_sbox(b[((c + 3*r) % 4)*4 + r]) ^ rk[127-8*(c*4+r) -: 8];
      for (int c = 0; c < 4; c++) begin
         a0 = g[c*4]; a1 = g[c*4+1]; a2 = g[c*4+2]; a3 = g[c*4+3];
         // Premultiply by {04}x^2+{05} then apply the forward mix.
         q0 = xtime(xtime(a0 ^ a2)); q1 = xtime(xtime(a1 ^ a3));
         a0 = a0 ^ q0; a2 = a2 ^ q0; a1 = a1 ^ q1; a3 = a3 ^ q1;
         d0 = xtime(a0); d1 = xtime(a1); d2 = xtime(a2); d3 = xtime(a3);
         q0 = d0 ^ d1 ^ a1 ^ a2 ^ a3;
         q1 = a0 ^ d1 ^ d2 ^ a2 ^ a3;
         q2 = a0 ^ a1 ^ d2 ^ d3 ^ a3;
         q3 = d0 ^ a0 ^ a1 ^ a2 ^ d3;
         m[c*4]   = cmd.last_round ? g[c*4]   : q0;
         m[c*4+1] = cmd.last_round ? g[c*4+1] : q1;
         m[c*4+2] = cmd.last_round ? g[c*4+2] : q2;
         m[c*4+3] = cmd.last_round ? g[c*4+3] : q3;
      end
      for (int i = 0; i < 16; i++) inv[127-8*i -: 8] = m[i];
   end

   always_comb begin
      st_in = st_ff;
      if (cmd.load_block) st_in = {req_data.block_upper, req_data.block_lower};
      else if (cmd.init_add) st_in = st_ff ^ rk;
      else if (cmd.do_round) st_in = dec_ff ? inv : fwd;
   end

   always_ff @(posedge clock) begin
      st_ff <= st_in;
      if (cmd.load_block) dec_ff <= req_data.action;
      if (cmd.rsp_load) rsp_ff <= {st_ff[127:64], st_ff[63:0]};
   end
   assign rsp_data = rsp_ff;

   `ASSERT_IMPL(a_idx_range, clock, reset, cmd.key_exp, cmd.key_idx < 6'(KeyWords), "key index")
   `ASSERT_IMPL(a_one_op, clock, reset, cmd.do_round, !cmd.load_block && !cmd.init_add, "op clash")
   `ASSERT_NEXT(a_rcon, clock, reset, cmd.key_load, rcon_ff == 8'h01, "rcon")
endmodule
`default_nettype wire

// ----- src/aes_control.sv -----
// Controller of the AES cipher unit: schedule flag, key expansion and round sequencing.
// Depends on aes_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module aes_control
   import aes_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic csr_write,
   input  wire logic [2:0] csr_index,
   input  wire logic req_valid,
   output logic      req_stall,
   output logic      rsp_valid,
   input  wire logic rsp_stall,
   input  wire sts_type sts,
   output cmd_type   cmd
);
   state_type  state_ff, state_in;
   logic       sched_ff, sched_in;
   logic       pend_ff, pend_in;
   logic       rv_ff, rv_in;
   logic [5:0] idx_ff, idx_in;
   logic [3:0] rnd_ff, rnd_in;
   logic [5:0] total;

   assign total = {sts.nk, 2'b00} + 6'd28;
   assign req_stall = (state_ff != ST_IDLE) || pend_ff;
   assign rsp_valid = rv_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         sched_ff <= 1'b0;
         pend_ff <= 1'b0;
         rv_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         sched_ff <= sched_in;
         pend_ff <= pend_in;
         rv_ff <= rv_in;
      end
      idx_ff <= idx_in;
      rnd_ff <= rnd_in;
   end

   always_comb begin
      state_in = state_ff;
      sched_in = sched_ff;
      idx_in = idx_ff;
      rnd_in = rnd_ff;
      pend_in = pend_ff;
      rv_in = rv_ff && rsp_stall;
      cmd = '0;
      cmd.key_idx = idx_ff;
      cmd.round = rnd_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid && !req_stall) begin
               cmd.load_block = 1'b1;
               pend_in = 1'b1;
               state_in = sched_ff ? ST_INIT : ST_KEY_LOAD;
            end
            rnd_in = '0;
         end
         ST_KEY_LOAD: begin
            cmd.key_load = 1'b1;
            idx_in = '0;
            state_in = ST_KEY_EXP;
         end
         ST_KEY_EXP: begin
            cmd.key_exp = 1'b1;
            idx_in = idx_ff + 6'd1;
            if (idx_ff == total - 6'd1) begin
               sched_in = 1'b1;
               state_in = ST_INIT;
            end
         end
         ST_INIT: begin
            // Round key address is presented here; the memory read lands next cycle.
            cmd.round = sts.decrypt ? sts.nr : 4'd0;
            rnd_in = sts.decrypt ? sts.nr : 4'd0;
            state_in = ST_ROUND;
         end
         ST_ROUND: begin
            if (rnd_ff == (sts.decrypt ? sts.nr : 4'd0) && idx_ff != 6'h3f) begin
               cmd.init_add = 1'b1;
               idx_in = 6'h3f;
            end else begin
               cmd.do_round = 1'b1;
               cmd.last_round = sts.decrypt ? (rnd_ff == 4'd0) : (rnd_ff == sts.nr);
               if (cmd.last_round) state_in = ST_OUT;
            end
            rnd_in = sts.decrypt ? rnd_ff - 4'd1 : rnd_ff + 4'd1;
            if (cmd.last_round) rnd_in = rnd_ff;
            cmd.round = rnd_in;
         end
         ST_OUT: begin
            if (!rv_ff || !rsp_stall) begin
               cmd.rsp_load = 1'b1;
               rv_in = 1'b1;
               pend_in = 1'b0;
               idx_in = '0;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
      if (csr_write && csr_index <= CsrKey3) sched_in = 1'b0;
   end

   `ASSERT_NEXT(a_rsp_hold, clock, reset, rv_ff && rsp_stall, rv_ff, "rsp dropped")
   `ASSERT_IMPL(a_busy_stall, clock, reset, state_ff != ST_IDLE, req_stall, "busy accept")
   `ASSERT_NEXT(a_exp_done, clock, reset, state_ff == ST_KEY_EXP && state_in == ST_INIT, sched_ff || csr_write, "sched")
endmodule
`default_nettype wire

// ----- src/aes_block_cipher_unit.sv -----
// AES-128/192/256 cipher unit: top level joining the controller and the datapath.
// Depends on aes_pkg, aes_control and aes_datapath.
//
// One request carries an action bit (0 encrypt, 1 decrypt) and a 128-bit block
// as two 64-bit halves, byte 0 in the top bits of the upper half. One response
// returns the resulting block in the same layout.
// The user must write the key mode and four 64-bit key parts through the csr port
// only while idle; the block itself does not enforce it. Any write to them marks
// the round-key schedule stale. The first request after that loads the key and
// then expands it one word per cycle into 44, 52 or 60 words in four 15-word banks.
// With a built schedule a request fetches the first round key, does the initial
// key addition, runs one round after another (10, 12 or 14) through a single
// shared round unit, and then registers the response.
// One request is in flight at a time; a new request is accepted once the
// previous response is registered, even while it is still stalled.
// Reset clears the key registers to zero, marks the schedule stale and drops
// any response. A stalled response holds its data until taken.
`default_nettype none
module aes_block_cipher_unit
   import aes_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire req_type     req_data,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output rsp_type          rsp_data,
   input  wire logic        csr_write,
   input  wire logic [2:0]  csr_index,
   input  wire logic [63:0] csr_data
);
   cmd_type cmd;
   sts_type sts;

   aes_control u_ctrl (
      .clock, .reset, .csr_write, .csr_index, .req_valid, .req_stall,
      .rsp_valid, .rsp_stall, .sts, .cmd
   );

   aes_datapath u_dp (
      .clock, .reset, .csr_write, .csr_index, .csr_data, .req_data, .cmd, .sts, .rsp_data
   );
endmodule
`default_nettype wire

// ----- dv/aes_block_cipher_checker.sv -----
// Checker for the AES cipher unit: watches the request, response and csr ports,
// predicts each response with its own AES model and compares it. Depends on aes_pkg.
`default_nettype none
module aes_block_cipher_checker
   import aes_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   input  wire logic        req_stall,
   input  wire req_type     req_data,
   input  wire logic        rsp_valid,
   input  wire logic        rsp_stall,
   input  wire rsp_type     rsp_data,
   input  wire logic        csr_write,
   input  wire logic [2:0]  csr_index,
   input  wire logic [63:0] csr_data,
   output int               mismatch_count,
   output int               pending_count,
   output int               response_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [7:0] FwdSbox [256] = '{
 8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
 8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
 8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
 8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
 8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
 8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
 8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
 8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
 8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
 8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
 8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
 8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
 8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
 8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
 8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
 8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};

   logic [1:0]  mode_q;
   logic [63:0] key_q [4];
   logic [31:0] sched [60];
   logic        sched_ok;
   rsp_type     expected_blocks [$];

   function automatic logic [7:0] dbl(input logic [7:0] v);
      return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
   endfunction

   function automatic logic [7:0] gmul(input logic [7:0] v, input logic [7:0] k);
      logic [7:0] acc;
      acc = 0;
      for (int b = 0; b < 8; b++) begin
         if (k[b]) acc ^= v;
         v = dbl(v);
      end
      return acc;
   endfunction

   function automatic logic [7:0] inv_lookup(input logic [7:0] x);
      for (int i = 0; i < 256; i++) if (FwdSbox[i] == x) return i[7:0];
      return 0;
   endfunction

   function automatic logic [31:0] subw(input logic [31:0] w);
      return {FwdSbox[w[31:24]], FwdSbox[w[23:16]], FwdSbox[w[15:8]], FwdSbox[w[7:0]]};
   endfunction

   function automatic int key_word_count();
      return (mode_q == 2'd3) ? 8 : 4 + 2 * mode_q;
   endfunction

   task automatic build_schedule();
      int nk;
      logic [31:0] rc, t;
      logic [31:0] src [8];
      nk = key_word_count();
      rc = 32'h0100_0000;
      for (int i = 0; i < 4; i++) begin
         src[2*i] = key_q[i][63:32];
         src[2*i+1] = key_q[i][31:0];
      end
      for (int i = 0; i < nk; i++) sched[i] = src[i];
      for (int i = nk; i < 4 * (nk + 7); i++) begin
         t = sched[i-1];
         if (i % nk == 0) begin
            t = subw({t[23:0], t[31:24]}) ^ rc;
            rc = {dbl(rc[31:24]), 24'h0};
         end else if (nk > 6 && i % nk == 4) begin
            t = subw(t);
         end
         sched[i] = sched[i-nk] ^ t;
      end
      sched_ok = 1;
   endtask

   task automatic add_round_key(inout logic [7:0] s [16], input int rnd);
      for (int c = 0; c < 4; c++)
         for (int r = 0; r < 4; r++) s[c*4+r] ^= sched[rnd*4+c][31-8*r -: 8];
   endtask

   task automatic rotate_rows(inout logic [7:0] s [16], input int dir);
      logic [7:0] t [16];
      for (int c = 0; c < 4; c++)
         for (int r = 0; r < 4; r++) t[c*4+r] = s[((c + dir*r) & 3)*4 + r];
      s = t;
   endtask

   task automatic mix(inout logic [7:0] s [16], input logic [7:0] k [4]);
      logic [7:0] col [4];
      for (int c = 0; c < 4; c++) begin
         for (int r = 0; r < 4; r++) begin
            col[r] = 0;
            for (int j = 0; j < 4; j++) col[r] ^= gmul(s[c*4+j], k[(j-r) & 3]);
         end
         for (int r = 0; r < 4; r++) s[c*4+r] = col[r];
      end
   endtask

   task automatic cipher_block(input req_type rq, output rsp_type rs);
      logic [7:0] s [16];
      logic [7:0] fk [4];
      logic [7:0] ik [4];
      int nr;
      fk = '{8'h02, 8'h03, 8'h01, 8'h01};
      ik = '{8'h0e, 8'h0b, 8'h0d, 8'h09};
      if (!sched_ok) build_schedule();
      nr = key_word_count() + 6;
      for (int i = 0; i < 8; i++) begin
         s[i] = rq.block_upper[63-8*i -: 8];
         s[8+i] = rq.block_lower[63-8*i -: 8];
      end
      if (!rq.action) begin
         add_round_key(s, 0);
         for (int rnd = 1; rnd <= nr; rnd++) begin
            for (int i = 0; i < 16; i++) s[i] = FwdSbox[s[i]];
            rotate_rows(s, 1);
            if (rnd != nr) mix(s, fk);
            add_round_key(s, rnd);
         end
      end else begin
         add_round_key(s, nr);
         for (int rnd = nr; rnd > 0; rnd--) begin
            rotate_rows(s, 3);
            for (int i = 0; i < 16; i++) s[i] = inv_lookup(s[i]);
            add_round_key(s, rnd - 1);
            if (rnd != 1) mix(s, ik);
         end
      end
      for (int i = 0; i < 8; i++) begin
         rs.result_upper[63-8*i -: 8] = s[i];
         rs.result_lower[63-8*i -: 8] = s[8+i];
      end
   endtask

   task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
      $display("%0t: mismatch in %s: got %h, expected %h", $realtime, what, got, want);
      mismatch_count++;
   endtask

   initial mismatch_count = 0;
   assign pending_count = expected_blocks.size();

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         mode_q = 0;
         key_q = '{default: 0};
         sched_ok = 0;
         expected_blocks.delete();
         response_count = 0;
      end else begin
         if (csr_write) begin
            case (csr_index)
               CsrKeyMode: mode_q = csr_data[1:0];
               CsrKey0: key_q[0] = csr_data;
               CsrKey1: key_q[1] = csr_data;
               CsrKey2: key_q[2] = csr_data;
               CsrKey3: key_q[3] = csr_data;
               default: ;
            endcase
            if (csr_index <= CsrKey3) sched_ok = 0;
         end
         if (rsp_valid && !rsp_stall) begin
            response_count++;
            if (expected_blocks.size() == 0) begin
               report("unexpected response", rsp_data.result_upper, 0);
            end else begin
               want = expected_blocks.pop_front();
               if (rsp_data.result_upper !== want.result_upper)
                  report("result_upper", rsp_data.result_upper, want.result_upper);
               if (rsp_data.result_lower !== want.result_lower)
                  report("result_lower", rsp_data.result_lower, want.result_lower);
            end
         end
         if (req_valid && !req_stall) begin
            cipher_block(req_data, want);
            expected_blocks.push_back(want);
         end
      end
   end
endmodule
`default_nettype wire

// ----- dv/aes_block_cipher_unit_test.sv -----
// Testbench top for the AES cipher unit: drives requests and key writes with
// random gaps and stalls, and gives the verdict. Depends on aes_pkg and the checker.
`default_nettype none
module aes_block_cipher_unit_test;
   import aes_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_stall;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_stall = 0;
   rsp_type     rsp_data;
   logic        csr_write = 0;
   logic [2:0]  csr_index = '0;
   logic [63:0] csr_data = '0;
   int          mismatch_count, pending_count, response_count;
   int          cycle_count = 0;
   bit          calm = 0;
   int          blocks_sent = 0;
   int          encrypts = 0, decrypts = 0;

   always #4 clock = ~clock;

   aes_block_cipher_unit i_dut (.*);

   aes_block_cipher_checker i_checker (.*);

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 400000) begin
         $display("Timeout after %0d cycles", cycle_count);
         $display("Mismatches found");
         $finish;
      end
   end

   // Response stall comes in random bursts, none in the calm tail.
   initial begin
      forever begin
         @(negedge clock);
         if (!calm && $urandom_range(0, 5) == 0) begin
            rsp_stall <= 1;
            repeat ($urandom_range(1, 16)) @(negedge clock);
            rsp_stall <= 0;
         end
      end
   end

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   task automatic write_csr(input logic [2:0] idx, input logic [63:0] val);
      req_valid <= 0;
      @(negedge clock);
      csr_write <= 1;
      csr_index <= idx;
      csr_data <= val;
      @(negedge clock);
      csr_write <= 0;
   endtask

   task automatic drain();
      req_valid <= 0;
      while (pending_count != 0) @(negedge clock);
      repeat (80) @(negedge clock);
   endtask

   // The valid stays high after an accept; the block is busy then, and the
   // next call either replaces the request or drops the valid.
   task automatic send_block(input logic act, input logic [63:0] up, input logic [63:0] lo);
      if (!calm && $urandom_range(0, 4) == 0) begin
         req_valid <= 0;
         repeat ($urandom_range(1, 16)) @(negedge clock);
      end
      req_valid <= 1;
      req_data <= '{action: act, block_upper: up, block_lower: lo};
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
      blocks_sent++;
      if (act) decrypts++; else encrypts++;
   endtask

   task automatic load_key(input logic [1:0] mode, input logic [63:0] k0, input logic [63:0] k1,
                           input logic [63:0] k2, input logic [63:0] k3);
      drain();
      write_csr(CsrKeyMode, {62'h0, mode});
      write_csr(CsrKey0, k0);
      write_csr(CsrKey1, k1);
      write_csr(CsrKey2, k2);
      write_csr(CsrKey3, k3);
   endtask

   initial begin
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // All-zero key straight out of reset.
      send_block(0, '0, '0);
      send_block(1, '0, '0);
      // Standard test vectors for the 128-bit and 256-bit key lengths.
      load_key(0, 64'h0001020304050607, 64'h08090a0b0c0d0e0f, 0, 0);
      send_block(0, 64'h0011223344556677, 64'h8899aabbccddeeff);
      send_block(1, 64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a);
      drain();
      write_csr(CsrKeyMode, 64'd1);
      send_block(0, 64'h0011223344556677, 64'h8899aabbccddeeff);
      drain();
      write_csr(CsrKey2, 64'h1011121314151617);
      send_block(1, 64'hffffffffffffffff, 64'hffffffffffffffff);
      drain();
      write_csr(CsrKeyMode, 64'd2);
      write_csr(CsrKey3, 64'h18191a1b1c1d1e1f);
      send_block(0, 64'h0011223344556677, 64'h8899aabbccddeeff);
      send_block(1, 64'h8ea2b7ca516745bf, 64'heafc49904b496089);
      // Reserved key mode behaves as the 256-bit mode; rewriting a value restales.
      drain();
      write_csr(CsrKeyMode, 64'hffffffffffffffff);
      send_block(0, 64'hffffffffffffffff, 0);
      drain();
      write_csr(CsrKey3, 64'h18191a1b1c1d1e1f);
      write_csr(3'd7, rand64());
      send_block(1, 0, 64'hffffffffffffffff);
      load_key(0, '1, '1, '1, '1);
      send_block(0, '1, '1);
      send_block(1, '1, '1);

      // Pause until everything has come back.
      drain();

      for (int phase = 0; phase < 12; phase++) begin
         load_key(phase == 11 ? 2'd3 : 2'(phase % 3), rand64(), rand64(), rand64(), rand64());
         if (phase >= 10) calm = 1;
         repeat (110) send_block($urandom_range(0, 1), rand64(), rand64());
      end
      drain();

      $display("Sent %0d requests (%0d encrypt, %0d decrypt), got %0d responses",
               blocks_sent, encrypts, decrypts, response_count);
      $display("Covered all key modes, the reserved mode and standard vectors");
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end
endmodule
`default_nettype wire

// ----- files.f -----
+incdir+src
src/aes_pkg.sv
src/aes_datapath.sv
src/aes_control.sv
src/aes_block_cipher_unit.sv
dv/aes_block_cipher_checker.sv
dv/aes_block_cipher_unit_test.sv
